### design/ssb_rem_pkg.sv
// ----------------------------------------------------------------------------
// ssb resource element mapper package
// shared widths, codes, constants and controller/datapath interface structs
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssb_rem_pkg;

   // grid geometry
   localparam int unsigned SymWidth = 2;
   localparam int unsigned ScWidth  = 8;
   localparam logic [ScWidth-1:0] SC_LAST       = 8'd239;
   localparam logic [ScWidth-1:0] SYNC_LO       = 8'd56;
   localparam logic [ScWidth-1:0] SYNC_HI_EXCL  = 8'd183;
   localparam logic [ScWidth-1:0] PBCH_LO_END   = 8'd48;
   localparam logic [ScWidth-1:0] PBCH_HI_START = 8'd192;

   // sample and register widths
   localparam int unsigned SampleWidth = 16;
   localparam int unsigned CellIdWidth = 10;
   localparam int unsigned SeedWidth   = 31;
   localparam int unsigned KindWidth   = 3;

   // pseudo-random generator
   localparam logic [SeedWidth-1:0] LCG_MUL       = 31'd1103515245;
   localparam logic [SeedWidth-1:0] LCG_ADD       = 31'd12345;
   localparam int unsigned          LcgBit        = 16;
   localparam logic [CellIdWidth-1:0] CELL_ID_RST = 10'd276;
   localparam logic [SeedWidth-1:0] DMRS_SEED_RST = 31'd575488;

   // element values, q1.15
   localparam logic signed [SampleWidth-1:0] ONE_SAT  = 16'sd32767;
   localparam logic signed [SampleWidth-1:0] DMRS_POS = 16'sd23170;
   localparam logic signed [SampleWidth-1:0] DMRS_NEG = -16'sd23170;
   localparam logic signed [SampleWidth-1:0] ZERO_VAL = 16'sd0;

   // element kinds
   localparam logic [KindWidth-1:0] KIND_EMPTY = 3'd0;
   localparam logic [KindWidth-1:0] KIND_PSS   = 3'd1;
   localparam logic [KindWidth-1:0] KIND_SSS   = 3'd2;
   localparam logic [KindWidth-1:0] KIND_DATA  = 3'd3;
   localparam logic [KindWidth-1:0] KIND_DMRS  = 3'd4;

   // configuration register indexes
   localparam int unsigned CsrAddrWidth = 1;
   localparam logic [CsrAddrWidth-1:0] CSR_CELL_ID   = 1'b0;
   localparam logic [CsrAddrWidth-1:0] CSR_DMRS_SEED = 1'b1;

   // stream widths
   localparam int unsigned ReqDataWidth = 32;
   localparam int unsigned RspDataWidth = 48;
   localparam int unsigned RspUserWidth = 4;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_GEN0 = 4'b0010,
      ST_GEN1 = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic accept;  // take the offered item into the item stage
      logic gen0;    // first generator step
      logic gen1;    // second generator step
      logic emit;    // load the output register
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic is_dmrs;   // current grid position is a dmrs element
      logic out_free;  // output register empty or draining this cycle
   } status_type;

endpackage

`default_nettype wire

### design/ssb_resource_element_mapper_unit.sv
// ----------------------------------------------------------------------------
// ssb resource element mapper
// walks the 4 x 240 ss/pbch block grid and emits one resource element per
// accepted transfer: pss, sss, pbch dmrs, pbch data or empty
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  req     | in        | req_tvalid/req_tready | tdata: data_i, data_q
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: position, value; tuser: kind,
//          |           |                       | took flag; tlast: end of block
//  csr     | in        | csr_we                | csr_addr, csr_wdata
//
// pss, sss, pbch data and empty elements go straight to emit when the
// result side drains; a dmrs element first passes through states gen0 and gen1 for the
// two dependent steps of the generator through its single 31-bit multiplier
// reset puts the walk at symbol 0 subcarrier 0 and loads register defaults
// one finished result waits in the output register while the next transfer
// is taken into the item stage; further input stalls until the result drains
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssb_resource_element_mapper_unit
   import ssb_rem_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // offered pbch sample
   input  wire logic                     req_tvalid,
   output      logic                     req_tready,
   input  wire logic [ReqDataWidth-1:0]  req_tdata,   // data_i [15:0], data_q [31:16]
   // mapped resource element
   output      logic                     rsp_tvalid,
   input  wire logic                     rsp_tready,
   output      logic [RspDataWidth-1:0]  rsp_tdata,   // symbol_index [1:0], subcarrier [9:2],
                                                      // value_i [25:10], value_q [41:26], zero fill
   output      logic [RspUserWidth-1:0]  rsp_tuser,   // re_kind [2:0], took_data [3]
   output      logic                     rsp_tlast,   // last_of_block
   // configuration writes
   input  wire logic                     csr_we,
   input  wire logic [CsrAddrWidth-1:0]  csr_addr,    // 0 cell_id, 1 dmrs_seed
   input  wire logic [SeedWidth-1:0]     csr_wdata
);

   cmd_type    cmd;
   status_type status;

   // controller: one-hot sequencer for accept, generator steps and emit
   ssb_rem_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // datapath: grid walk, classification, generator and result registers
   ssb_rem_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // a result never overwrites one still waiting in the output register
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (!rsp_tvalid || rsp_tready))
      else $error("result loaded over a pending output transfer");

   // the two generator steps always run back to back
   a_gen_pair: assert property (@(posedge clock) disable iff (reset)
      cmd.gen0 |=> cmd.gen1)
      else $error("generator step pair broken");

   // end of block only on the final grid element
   a_last_pos: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> ((rsp_tdata[1:0] == 2'd3) &&
                                     (rsp_tdata[9:2] == SC_LAST)))
      else $error("tlast away from the final element");

   // a consumed sample only ever maps to a pbch data element
   a_took_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[3]) |-> (rsp_tuser[2:0] == KIND_DATA))
      else $error("sample consumed at a non-data element");

endmodule

`default_nettype wire

### design/ssb_rem_ctrl.sv
// ----------------------------------------------------------------------------
// ssb resource element mapper controller
// sequences item acceptance, generator steps and result emission
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssb_rem_ctrl
   import ssb_rem_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_tvalid,
   output      logic       req_tready,
   input  wire status_type status,
   output      cmd_type    cmd
);

   state_type state_ff, state_in;
   logic      ready;
   logic      accept;

   // the item stage frees up as soon as its result moves into the output register
   assign ready  = (state_ff == ST_IDLE) || ((state_ff == ST_EMIT) && status.out_free);
   assign accept = ready && req_tvalid;

   assign req_tready = ready;
   assign cmd.accept = accept;
   assign cmd.gen0   = (state_ff == ST_GEN0);
   assign cmd.gen1   = (state_ff == ST_GEN1);
   assign cmd.emit   = (state_ff == ST_EMIT) && status.out_free;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = status.is_dmrs ? ST_GEN0 : ST_EMIT;
            end
         end
         ST_GEN0: begin
            state_in = ST_GEN1;
         end
         ST_GEN1: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (status.out_free) begin
               if (accept) begin
                  state_in = status.is_dmrs ? ST_GEN0 : ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

### design/ssb_rem_dpath.sv
// ----------------------------------------------------------------------------
// ssb resource element mapper datapath
// grid position, classification, dmrs generator, item stage and output register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssb_rem_dpath
   import ssb_rem_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire cmd_type                  cmd,
   output      status_type               status,
   input  wire logic                     csr_we,
   input  wire logic [CsrAddrWidth-1:0]  csr_addr,
   input  wire logic [SeedWidth-1:0]     csr_wdata,
   input  wire logic [ReqDataWidth-1:0]  req_tdata,
   input  wire logic                     rsp_tready,
   output      logic                     rsp_tvalid,
   output      logic [RspDataWidth-1:0]  rsp_tdata,
   output      logic [RspUserWidth-1:0]  rsp_tuser,
   output      logic                     rsp_tlast
);

   // configuration
   logic [CellIdWidth-1:0] cell_id_ff;
   logic [SeedWidth-1:0]   dmrs_seed_ff;

   // grid position of the next element
   logic [SymWidth-1:0] sym_ff, sym_in;
   logic [ScWidth-1:0]  sc_ff, sc_in;

   // generator
   logic [SeedWidth-1:0] lcg_ff, lcg_in;
   logic [SeedWidth-1:0] lcg_step;
   logic                 b0_ff, b1_ff;

   // item stage
   logic [SymWidth-1:0]           item_sym_ff;
   logic [ScWidth-1:0]            item_sc_ff;
   logic [KindWidth-1:0]          item_kind_ff;
   logic signed [SampleWidth-1:0] item_di_ff, item_dq_ff;

   // output register
   logic                    rsp_tvalid_ff, rsp_tvalid_in;
   logic [RspDataWidth-1:0] rsp_tdata_ff;
   logic [RspUserWidth-1:0] rsp_tuser_ff;
   logic                    rsp_tlast_ff;

   // classification of the current position
   logic                 sync_band, pbch_band, dmrs_pos;
   logic [KindWidth-1:0] kind;

   // emitted values
   logic signed [SampleWidth-1:0] val_i, val_q;
   logic                          took;
   logic                          last;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_id_ff   <= CELL_ID_RST;
         dmrs_seed_ff <= DMRS_SEED_RST;
      end else if (csr_we) begin
         unique case (csr_addr)
            CSR_CELL_ID:   cell_id_ff   <= csr_wdata[CellIdWidth-1:0];
            CSR_DMRS_SEED: dmrs_seed_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign sync_band = (sc_ff >= SYNC_LO) && (sc_ff < SYNC_HI_EXCL);
   assign pbch_band = (sym_ff == 2'd1) || (sym_ff == 2'd3) ||
                      ((sym_ff == 2'd2) && ((sc_ff < PBCH_LO_END) || (sc_ff >= PBCH_HI_START)));
   assign dmrs_pos  = (sc_ff[1:0] == cell_id_ff[1:0]);

   always_comb begin
      if ((sym_ff == 2'd0) && sync_band) begin
         kind = KIND_PSS;
      end else if ((sym_ff == 2'd2) && sync_band) begin
         kind = KIND_SSS;
      end else if (pbch_band && dmrs_pos) begin
         kind = KIND_DMRS;
      end else if (pbch_band) begin
         kind = KIND_DATA;
      end else begin
         kind = KIND_EMPTY;
      end
   end

   assign status.is_dmrs  = (kind == KIND_DMRS);
   assign status.out_free = !rsp_tvalid_ff || rsp_tready;

   // position walk, subcarrier fastest
   always_comb begin
      sym_in = sym_ff;
      sc_in  = sc_ff;
      if (cmd.accept) begin
         if (sc_ff == SC_LAST) begin
            sc_in  = '0;
            sym_in = sym_ff + 2'd1;
         end else begin
            sc_in = sc_ff + 8'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= '0;
         sc_ff  <= '0;
      end else begin
         sym_ff <= sym_in;
         sc_ff  <= sc_in;
      end
   end

   // one multiply-add per cycle, modulo 2^31 by truncation
   assign lcg_step = lcg_ff * LCG_MUL + LCG_ADD;

   always_comb begin
      lcg_in = lcg_ff;
      if (cmd.accept && (sym_ff == 2'd0) && (sc_ff == '0)) begin
         lcg_in = dmrs_seed_ff;
      end else if (cmd.gen0 || cmd.gen1) begin
         lcg_in = lcg_step;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcg_ff <= DMRS_SEED_RST;
      end else begin
         lcg_ff <= lcg_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.gen0) begin
         b0_ff <= lcg_step[LcgBit];
      end
      if (cmd.gen1) begin
         b1_ff <= lcg_step[LcgBit];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         item_sym_ff  <= sym_ff;
         item_sc_ff   <= sc_ff;
         item_kind_ff <= kind;
         item_di_ff   <= req_tdata[SampleWidth-1:0];
         item_dq_ff   <= req_tdata[2*SampleWidth-1:SampleWidth];
      end
   end

   always_comb begin
      val_i = ZERO_VAL;
      val_q = ZERO_VAL;
      took  = 1'b0;
      case (item_kind_ff) inside
         KIND_PSS, KIND_SSS: begin
            val_i = ONE_SAT;
         end
         KIND_DMRS: begin
            val_i = b0_ff ? DMRS_NEG : DMRS_POS;
            val_q = b1_ff ? DMRS_NEG : DMRS_POS;
         end
         KIND_DATA: begin
            val_i = item_di_ff;
            val_q = item_dq_ff;
            took  = 1'b1;
         end
         default: ;
      endcase
   end

   assign last = (item_sym_ff == 2'd3) && (item_sc_ff == SC_LAST);

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff;
      if (cmd.emit) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_tvalid_ff <= 1'b0;
      end else begin
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_tdata_ff <= {6'd0, val_q, val_i, item_sc_ff, item_sym_ff};
         rsp_tuser_ff <= {took, item_kind_ff};
         rsp_tlast_ff <= last;
      end
   end

   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_tdata_ff;
   assign rsp_tuser  = rsp_tuser_ff;
   assign rsp_tlast  = rsp_tlast_ff;

endmodule

`default_nettype wire

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssb resource element mapper testbench
// walks the ss/pbch grid through the stream ports: a table of directed
// positions first, then random samples under several register settings and
// idle patterns; each element is checked against a typed row or the bench model
// ----------------------------------------------------------------------------

module tb_top;
   import ssb_rem_pkg::*;

   // one mapped resource element, as seen on the result channel
   typedef struct packed {
      logic [SymWidth-1:0]          sym;
      logic [ScWidth-1:0]           sc;
      logic [KindWidth-1:0]         kind;
      logic [SampleWidth-1:0]       vi;
      logic [SampleWidth-1:0]       vq;
      logic                         took;
      logic                         last;
   } re_type;

   // directed table row: grid position to reach, sample to offer there,
   // and a typed-in element where it is obvious
   typedef struct packed {
      logic [SymWidth-1:0]          sym;
      logic [ScWidth-1:0]           sc;
      logic [SampleWidth-1:0]       di;
      logic [SampleWidth-1:0]       dq;
      logic                         typed;
      logic [KindWidth-1:0]         kind;
      logic [SampleWidth-1:0]       vi;
      logic [SampleWidth-1:0]       vq;
      logic                         took;
      logic                         last;
   } row_type;

   localparam int NumRows = 22;

   // reset settings give a dmrs shift of 0, so data sits at k mod 4 != 0
   row_type dir_rows [NumRows] = '{
      // first element after reset: empty, offered sample dropped
      '{2'd0, 8'd0,   16'h7fff, 16'h8000, 1'b1, KIND_EMPTY, ZERO_VAL, ZERO_VAL, 1'b0, 1'b0},
      '{2'd0, 8'd55,  16'h1234, 16'h4321, 1'b1, KIND_EMPTY, ZERO_VAL, ZERO_VAL, 1'b0, 1'b0},
      // pss band edges
      '{2'd0, 8'd56,  16'hffff, 16'hffff, 1'b1, KIND_PSS,   ONE_SAT,  ZERO_VAL, 1'b0, 1'b0},
      '{2'd0, 8'd182, 16'h8000, 16'h8000, 1'b1, KIND_PSS,   ONE_SAT,  ZERO_VAL, 1'b0, 1'b0},
      '{2'd0, 8'd183, 16'h7fff, 16'h7fff, 1'b1, KIND_EMPTY, ZERO_VAL, ZERO_VAL, 1'b0, 1'b0},
      // first dmrs of the block
      '{2'd1, 8'd0,   16'h0f0f, 16'hf0f0, 1'b0, KIND_EMPTY, ZERO_VAL, ZERO_VAL, 1'b0, 1'b0},
      // data extremes pass straight through
      '{2'd1, 8'd1,   16'h8000, 16'h7fff, 1'b1, KIND_DATA,  16'h8000, 16'h7fff, 1'b1, 1'b0},
      '{2'd1, 8'd2,   16'h7fff, 16'h8000, 1'b1, KIND_DATA,  16'h7fff, 16'h8000, 1'b1, 1'b0},
      '{2'd1, 8'd3,   16'h0000, 16'h0000, 1'b1, KIND_DATA,  16'h0000, 16'h0000, 1'b1, 1'b0},
      '{2'd1, 8'd4,   16'h0001, 16'h0001, 1'b0, KIND_EMPTY, ZERO_VAL, ZERO_VAL, 1'b0, 1'b0},
      // symbol 2: low pbch edge, gap, sss band, gap, high pbch edge
      '{2'd2, 8'd47,  16'h5555, 16'haaaa, 1'b1, KIND_DATA,  16'h5555, 16'haaaa, 1'b1, 1'b0},
      '{2'd2, 8'd48,  16'hffff, 16'hffff, 1'b1, KIND_EMPTY, ZERO_VAL, ZERO_VAL, 1'b0, 1'b0},
      '{2'd2, 8'd56,  16'h1111, 16'h2222, 1'b1, KIND_SSS,   ONE_SAT,  ZERO_VAL, 1'b0, 1'b0},
      '{2'd2, 8'd182, 16'h3333, 16'h4444, 1'b1, KIND_SSS,   ONE_SAT,  ZERO_VAL, 1'b0, 1'b0},
      '{2'd2, 8'd191, 16'h6666, 16'h7777, 1'b1, KIND_EMPTY, ZERO_VAL, ZERO_VAL, 1'b0, 1'b0},
      '{2'd2, 8'd192, 16'h0000, 16'hffff, 1'b0, KIND_EMPTY, ZERO_VAL, ZERO_VAL, 1'b0, 1'b0},
      '{2'd2, 8'd193, 16'haaaa, 16'h5555, 1'b1, KIND_DATA,  16'haaaa, 16'h5555, 1'b1, 1'b0},
      '{2'd3, 8'd0,   16'h1234, 16'h5678, 1'b0, KIND_EMPTY, ZERO_VAL, ZERO_VAL, 1'b0, 1'b0},
      '{2'd3, 8'd238, 16'h0001, 16'hfffe, 1'b1, KIND_DATA,  16'h0001, 16'hfffe, 1'b1, 1'b0},
      // end of block flagged on tlast
      '{2'd3, 8'd239, 16'hffff, 16'h0001, 1'b1, KIND_DATA,  16'hffff, 16'h0001, 1'b1, 1'b1},
      // wrap back to the start, generator reseeded
      '{2'd0, 8'd0,   16'h8000, 16'h7fff, 1'b1, KIND_EMPTY, ZERO_VAL, ZERO_VAL, 1'b0, 1'b0},
      '{2'd1, 8'd0,   16'h2468, 16'h1357, 1'b0, KIND_EMPTY, ZERO_VAL, ZERO_VAL, 1'b0, 1'b0}
   };

   // clock, reset and dut ports
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [ReqDataWidth-1:0]  req_tdata = '0;   // data_i [15:0], data_q [31:16]
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RspDataWidth-1:0]  rsp_tdata;        // symbol_index [1:0], subcarrier [9:2],
                                               // value_i [25:10], value_q [41:26], zero fill
   logic [RspUserWidth-1:0]  rsp_tuser;        // re_kind [2:0], took_data [3]
   logic                     rsp_tlast;        // last_of_block
   logic                     csr_we = 1'b0;
   logic [CsrAddrWidth-1:0]  csr_addr = '0;
   logic [SeedWidth-1:0]     csr_wdata = '0;

   // model copy of the registers and of the grid walk
   logic [CellIdWidth-1:0]   cell_cfg = CELL_ID_RST;
   logic [SeedWidth-1:0]     seed_cfg = DMRS_SEED_RST;
   logic [SymWidth-1:0]      walk_sym = '0;
   logic [ScWidth-1:0]       walk_sc = '0;
   logic [SeedWidth-1:0]     prng_state = DMRS_SEED_RST;

   re_type pending_re [$];     // elements still to come out, oldest first

   int mismatches = 0;
   int n_sent = 0;
   int n_seen = 0;
   int n_dmrs = 0;
   int n_taken = 0;
   int n_blocks = 0;
   int n_settings = 1;
   int snd_idle_pct = 22;
   int rcv_idle_pct = 49;
   int hold_req_cnt = 0;       // bumped by the stimulus to ask for a long stall
   int hold_seen = 0;
   int hold_left = 0;

   ssb_resource_element_mapper_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #2 clock = ~clock;

   // one step of the 31-bit lcg; the product truncates to 31 bits by width
   function automatic logic dmrs_prng_bit();
      prng_state = prng_state * LCG_MUL + LCG_ADD;
      return prng_state[LcgBit];
   endfunction

   // element produced at the current grid position; advances the walk
   function automatic re_type map_next_element(input logic [SampleWidth-1:0] di,
                                                input logic [SampleWidth-1:0] dq);
      re_type e;
      logic   sync_band;
      logic   pbch_band;
      logic   dmrs_pos;
      logic   b0;
      logic   b1;
      e = '0;
      e.sym = walk_sym;
      e.sc = walk_sc;
      // generator restarts from the seed at the top of every block
      if (walk_sym == 2'd0 && walk_sc == 8'd0)
         prng_state = seed_cfg;
      sync_band = walk_sc >= SYNC_LO && walk_sc < SYNC_HI_EXCL;
      pbch_band = walk_sym == 2'd1 || walk_sym == 2'd3 ||
                  (walk_sym == 2'd2 && (walk_sc < PBCH_LO_END || walk_sc >= PBCH_HI_START));
      dmrs_pos = walk_sc[1:0] == cell_cfg[1:0];
      if (walk_sym == 2'd0 && sync_band) begin
         e.kind = KIND_PSS;
         e.vi = ONE_SAT;
      end else if (walk_sym == 2'd2 && sync_band) begin
         e.kind = KIND_SSS;
         e.vi = ONE_SAT;
      end else if (pbch_band && dmrs_pos) begin
         b0 = dmrs_prng_bit();
         b1 = dmrs_prng_bit();
         e.kind = KIND_DMRS;
         e.vi = b0 ? DMRS_NEG : DMRS_POS;
         e.vq = b1 ? DMRS_NEG : DMRS_POS;
      end else if (pbch_band) begin
         e.kind = KIND_DATA;
         e.vi = di;
         e.vq = dq;
         e.took = 1'b1;
      end else begin
         e.kind = KIND_EMPTY;
      end
      e.last = walk_sym == 2'd3 && walk_sc == SC_LAST;
      if (walk_sc == SC_LAST) begin
         walk_sc = '0;
         walk_sym = walk_sym + 2'd1;
      end else begin
         walk_sc = walk_sc + 8'd1;
      end
      return e;
   endfunction

   function automatic logic [SampleWidth-1:0] pick_sample();
      case ($urandom_range(7))
         0: return 16'h8000;
         1: return 16'h7fff;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return SampleWidth'($urandom);
      endcase
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 30)
         $display("mismatch: %s", msg);
   endtask

   task automatic check_field(input string name, input logic [SampleWidth-1:0] got,
                              input logic [SampleWidth-1:0] want, input re_type at);
      if (got !== want)
         report_mismatch($sformatf("%s at l=%0d k=%0d: got %0h, expected %0h",
                                   name, at.sym, at.sc, got, want));
   endtask

   // offer one sample; called at a falling edge and returns at one
   task automatic send_sample(input logic [SampleWidth-1:0] di,
                              input logic [SampleWidth-1:0] dq,
                              input logic use_typed, input re_type typed_re);
      re_type predicted;
      while ($urandom_range(99) < snd_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {dq, di};
      do
         @(posedge clock);
      while (!req_tready);
      // transfer accepted at this edge
      predicted = map_next_element(di, dq);
      if (use_typed)
         predicted = typed_re;
      pending_re = {pending_re, predicted};
      n_sent++;
      @(negedge clock);
   endtask

   // stop offering and wait until every element has come out
   task automatic drain(input int extra);
      req_tvalid <= 1'b0;
      do
         @(negedge clock);
      while (pending_re.size() != 0);
      repeat (extra) @(negedge clock);
   endtask

   // register write while the block is idle; csr_we is low again when the task returns
   task automatic write_csr(input logic [CsrAddrWidth-1:0] addr,
                            input logic [SeedWidth-1:0] data);
      csr_we <= 1'b1;
      csr_addr <= addr;
      csr_wdata <= data;
      if (addr == CSR_CELL_ID)
         cell_cfg = data[CellIdWidth-1:0];
      else
         seed_cfg = data;
      @(negedge clock);
      csr_we <= 1'b0;
      @(negedge clock);
   endtask

   // result side: random stalls, plus a long hold-off when asked for
   always @(negedge clock) begin
      if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else if (hold_req_cnt != hold_seen) begin
         hold_seen <= hold_req_cnt;
         hold_left <= 120;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= $urandom_range(99) >= rcv_idle_pct;
      end
   end

   // result checker: every transfer is compared with the oldest expectation
   always @(posedge clock) begin
      re_type got;
      re_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.sym = rsp_tdata[1:0];
         got.sc = rsp_tdata[9:2];
         got.vi = rsp_tdata[25:10];
         got.vq = rsp_tdata[41:26];
         got.kind = rsp_tuser[2:0];
         got.took = rsp_tuser[3];
         got.last = rsp_tlast;
         if (pending_re.size() == 0) begin
            report_mismatch($sformatf("transfer with nothing expected: l=%0d k=%0d kind=%0d",
                                      got.sym, got.sc, got.kind));
         end else begin
            want = pending_re.pop_front();
            check_field("symbol_index", 16'(got.sym), 16'(want.sym), want);
            check_field("subcarrier", 16'(got.sc), 16'(want.sc), want);
            check_field("re_kind", 16'(got.kind), 16'(want.kind), want);
            check_field("value_i", got.vi, want.vi, want);
            check_field("value_q", got.vq, want.vq, want);
            check_field("took_data", 16'(got.took), 16'(want.took), want);
            check_field("last_of_block", 16'(got.last), 16'(want.last), want);
            n_seen++;
            if (want.kind == KIND_DMRS)
               n_dmrs++;
            if (want.took)
               n_taken++;
            if (want.last)
               n_blocks++;
         end
      end
   end

   // overall limit
   initial begin
      #2_000_000;
      $display("timeout with %0d elements outstanding", pending_re.size());
      $display("Mismatches found");
      $finish;
   end

   initial begin
      re_type           typed_re;
      logic [SeedWidth-1:0] cell_word;
      logic [SeedWidth-1:0] seed_word;
      logic             write_seed;

      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part: walk to each table position, filling with random samples
      for (int r = 0; r < NumRows; r++) begin
         while (walk_sym != dir_rows[r].sym || walk_sc != dir_rows[r].sc)
            send_sample(pick_sample(), pick_sample(), 1'b0, '0);
         typed_re = '{sym: dir_rows[r].sym, sc: dir_rows[r].sc, kind: dir_rows[r].kind,
                      vi: dir_rows[r].vi, vq: dir_rows[r].vq, took: dir_rows[r].took,
                      last: dir_rows[r].last};
         send_sample(dir_rows[r].di, dir_rows[r].dq, dir_rows[r].typed, typed_re);
      end

      // random part: six settings, each written mid-block once the block is idle
      for (int p = 0; p < 6; p++) begin
         drain(6);
         write_seed = 1'b1;
         case (p)
            0: begin
               // cell id beyond the valid range, all-zero seed
               cell_word = 31'd1023;
               seed_word = '0;
            end
            1: begin
               cell_word = 31'd0;
               seed_word = 31'h7fffffff;
            end
            2: begin
               cell_word = 31'd1007;
               seed_word = SeedWidth'($urandom);
            end
            3: begin
               cell_word = 31'd1;
               seed_word = SeedWidth'($urandom);
            end
            4: begin
               cell_word = 31'd2;
               seed_word = '0;
               write_seed = 1'b0;
            end
            default: begin
               // junk above the cell id bits must be ignored
               cell_word = SeedWidth'($urandom);
               seed_word = SeedWidth'($urandom);
            end
         endcase
         write_csr(CSR_CELL_ID, cell_word);
         if (write_seed)
            write_csr(CSR_DMRS_SEED, seed_word);
         n_settings++;
         snd_idle_pct = p < 2 ? 22 : (p < 4 ? 49 : 0);
         rcv_idle_pct = p < 2 ? 49 : (p < 4 ? 22 : 0);
         for (int i = 0; i < 40; i++) begin
            // long result stall while samples keep coming: fills the block
            if (p == 1 && i == 10)
               hold_req_cnt++;
            // sender pause until everything has drained
            if (p == 3 && i == 20)
               drain(0);
            send_sample(pick_sample(), pick_sample(), 1'b0, '0);
         end
      end

      drain(10);
      $display("sent %0d samples, checked %0d elements (%0d dmrs, %0d data taken)",
               n_sent, n_seen, n_dmrs, n_taken);
      $display("%0d block ends seen over %0d register settings", n_blocks, n_settings);
      if (mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule
